>>> design/rth_pkg.sv
// Shared constants and register index codes for the ray/triangle hit test.
package rth_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int VERTEX_WIDTH    = 48;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VERTEX_A,
      CSR_VERTEX_B,
      CSR_VERTEX_C
   } csr_index_type;

endpackage

>>> design/ray_triangle_hit_test.sv
// Top level: pipelined Moller-Trumbore ray/triangle hit test against one configured triangle.
//
// Usage:
//   The triangle is set through the csr_ write channel: index 0, 1 and 2 load
//   vertex a, b and c, each packed z,y,x with x in the low bits. csr_ready is
//   always high; write only while no ray is in flight.
//   A ray is taken at a rising edge with start high and busy low. busy never
//   rises, so one ray can be taken in every cycle.
//   Each ray gives one beat on rsp_valid/rsp_hit. Throughput is one ray per
//   cycle. The registered stages, in order, are: origin offset, cross
//   products, cross differences, split partial products of the dot
//   products, their sum, sign fold by det, and the final compares.
//   The receiver cannot stall; every beat is shown for exactly one cycle.
//   Reset clears the vertices to zero and empties the pipeline; rays in
//   flight at reset are dropped.
module ray_triangle_hit_test
   import rth_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_heading_x,
   input  logic signed [COORD_WIDTH-1:0] req_heading_y,
   input  logic signed [COORD_WIDTH-1:0] req_heading_z,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [VERTEX_WIDTH-1:0]       csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int NW = CW + 1;
   localparam int PW = 2 * NW;
   localparam int WW = PW + 1;
   localparam int DW = NW + WW + 2;
   localparam int XW = VERTEX_WIDTH + 3 * CW;

   // configuration
   logic [VERTEX_WIDTH-1:0] vertex_in [3];
   logic [VERTEX_WIDTH-1:0] vertex_ff [3];
   logic signed [CW-1:0]    comp [3][3];
   logic signed [NW-1:0]    e1_in [3];
   logic signed [NW-1:0]    e1_ff [3];
   logic signed [NW-1:0]    e2_in [3];
   logic signed [NW-1:0]    e2_ff [3];

   // ray inputs
   logic signed [CW-1:0]    org_w [3];
   logic signed [CW-1:0]    dir_w [3];
   logic                    accept;

   // pipeline
   logic                    v_ff [6];
   logic signed [NW-1:0]    dir1_ff [3];
   logic signed [NW-1:0]    tv1_in [3];
   logic signed [NW-1:0]    tv1_ff [3];
   logic signed [PW-1:0]    ppv_in [3][2];
   logic signed [PW-1:0]    ppv_ff [3][2];
   logic signed [PW-1:0]    pqv_in [3][2];
   logic signed [PW-1:0]    pqv_ff [3][2];
   logic signed [NW-1:0]    dir2_ff [3];
   logic signed [NW-1:0]    tv2_ff [3];
   logic signed [WW-1:0]    pv3_in [3];
   logic signed [WW-1:0]    pv3_ff [3];
   logic signed [WW-1:0]    qv3_in [3];
   logic signed [WW-1:0]    qv3_ff [3];
   logic signed [NW-1:0]    dir3_ff [3];
   logic signed [NW-1:0]    tv3_ff [3];
   logic signed [DW-1:0]    det5;
   logic signed [DW-1:0]    nu5;
   logic signed [DW-1:0]    nv5;
   logic signed [DW-1:0]    nt5;
   logic                    flip5;
   logic signed [DW-1:0]    det6_ff;
   logic signed [DW-1:0]    nu6_ff;
   logic signed [DW-1:0]    nv6_ff;
   logic signed [DW-1:0]    nt6_ff;
   logic                    nz6_ff;
   logic signed [DW:0]      suv;
   logic                    hit_in;
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign org_w[0] = req_start_x;
   assign org_w[1] = req_start_y;
   assign org_w[2] = req_start_z;
   assign dir_w[0] = req_heading_x;
   assign dir_w[1] = req_heading_y;
   assign dir_w[2] = req_heading_z;

   always_comb begin
      vertex_in = vertex_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VERTEX_A: vertex_in[0] = csr_wdata;
            CSR_VERTEX_B: vertex_in[1] = csr_wdata;
            CSR_VERTEX_C: vertex_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vertex_ff[i] <= '0;
         end
      end else begin
         vertex_ff <= vertex_in;
      end
   end

   // components beyond the register bits read as zero
   for (genvar v = 0; v < 3; v++) begin : g_vtx
      logic [XW-1:0] ext;
      assign ext = {{(3 * CW){1'b0}}, vertex_ff[v]};
      for (genvar k = 0; k < 3; k++) begin : g_comp
         assign comp[v][k] = signed'(ext[k*CW +: CW]);
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_edge
      assign e1_in[k] = NW'(comp[1][k]) - NW'(comp[0][k]);
      assign e2_in[k] = NW'(comp[2][k]) - NW'(comp[0][k]);
      assign tv1_in[k] = NW'(org_w[k]) - NW'(comp[0][k]);
   end

   always_ff @(posedge clock) begin
      e1_ff <= e1_in;
      e2_ff <= e2_in;
   end

   // cross products: pv = dir x e2, qv = tv x e1
   for (genvar k = 0; k < 3; k++) begin : g_cross
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      assign ppv_in[k][0] = PW'(dir1_ff[K1]) * PW'(e2_ff[K2]);
      assign ppv_in[k][1] = PW'(dir1_ff[K2]) * PW'(e2_ff[K1]);
      assign pqv_in[k][0] = PW'(tv1_ff[K1]) * PW'(e1_ff[K2]);
      assign pqv_in[k][1] = PW'(tv1_ff[K2]) * PW'(e1_ff[K1]);
      assign pv3_in[k] = WW'(ppv_ff[k][0]) - WW'(ppv_ff[k][1]);
      assign qv3_in[k] = WW'(pqv_ff[k][0]) - WW'(pqv_ff[k][1]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dir1_ff[k] <= NW'(dir_w[k]);
      end
      tv1_ff  <= tv1_in;
      ppv_ff  <= ppv_in;
      pqv_ff  <= pqv_in;
      dir2_ff <= dir1_ff;
      tv2_ff  <= tv1_ff;
      pv3_ff  <= pv3_in;
      qv3_ff  <= qv3_in;
      dir3_ff <= dir2_ff;
      tv3_ff  <= tv2_ff;
   end

   rth_dot3 #(.NW(NW), .WW(WW)) u_det (
      .clock  (clock),
      .a      (e1_ff),
      .b      (pv3_ff),
      .result (det5)
   );

   rth_dot3 #(.NW(NW), .WW(WW)) u_nu (
      .clock  (clock),
      .a      (tv3_ff),
      .b      (pv3_ff),
      .result (nu5)
   );

   rth_dot3 #(.NW(NW), .WW(WW)) u_nv (
      .clock  (clock),
      .a      (dir3_ff),
      .b      (qv3_ff),
      .result (nv5)
   );

   rth_dot3 #(.NW(NW), .WW(WW)) u_nt (
      .clock  (clock),
      .a      (e2_ff),
      .b      (qv3_ff),
      .result (nt5)
   );

   // fold the sign of det into every numerator so the bounds become 0 and |det|
   assign flip5 = det5[DW-1];

   always_ff @(posedge clock) begin
      det6_ff <= flip5 ? -det5 : det5;
      nu6_ff  <= flip5 ? -nu5  : nu5;
      nv6_ff  <= flip5 ? -nv5  : nv5;
      nt6_ff  <= flip5 ? -nt5  : nt5;
      nz6_ff  <= (det5 != '0);
   end

   assign suv = (DW + 1)'(nu6_ff) + (DW + 1)'(nv6_ff);

   assign hit_in = nz6_ff
                && !nu6_ff[DW-1]
                && !(nu6_ff > det6_ff)
                && !nv6_ff[DW-1]
                && !(suv > (DW + 1)'(det6_ff))
                && !nt6_ff[DW-1] && (nt6_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            v_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff[0] <= accept;
         for (int i = 1; i < 6; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         rsp_valid_ff <= v_ff[5];
      end
      rsp_hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 rsp_valid)
      else $error("accepted ray produced no beat seven edges later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 7))
      else $error("result beat without an accepted ray");

   a_hit_needs_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $past(det5 != '0, 2))
      else $error("hit reported for a zero determinant");

   a_vertex_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(csr_valid && csr_ready) |->
         $stable(vertex_ff[0]) && $stable(vertex_ff[1]) && $stable(vertex_ff[2]))
      else $error("vertex register changed without a write");

endmodule

>>> design/rth_dot3.sv
// Two-stage dot product of a narrow and a wide three-vector, wide operand split in halves.
module rth_dot3 #(
   parameter int NW = 17,
   parameter int WW = 35
) (
   input  logic                     clock,
   input  logic signed [NW-1:0]     a [3],
   input  logic signed [WW-1:0]     b [3],
   output logic signed [NW+WW+1:0]  result
);

   localparam int LO_W = WW / 2;
   localparam int HI_W = WW - LO_W;
   localparam int LP_W = NW + LO_W + 1;
   localparam int HP_W = NW + HI_W;
   localparam int TW   = NW + WW;
   localparam int SW   = TW + 2;

   logic signed [LP_W-1:0] lo_in [3];
   logic signed [LP_W-1:0] lo_ff [3];
   logic signed [HP_W-1:0] hi_in [3];
   logic signed [HP_W-1:0] hi_ff [3];
   logic signed [TW-1:0]   term  [3];
   logic signed [SW-1:0]   sum_in;
   logic signed [SW-1:0]   sum_ff;

   for (genvar k = 0; k < 3; k++) begin : g_part
      logic signed [LO_W:0]   lo_op;
      logic signed [HI_W-1:0] hi_op;
      assign lo_op   = signed'({1'b0, b[k][LO_W-1:0]});
      assign hi_op   = signed'(b[k][WW-1:LO_W]);
      assign lo_in[k] = LP_W'(a[k]) * LP_W'(lo_op);
      assign hi_in[k] = HP_W'(a[k]) * HP_W'(hi_op);
      // recombine: high partial weighs 2^LO_W
      assign term[k] = (TW'(hi_ff[k]) <<< LO_W) + TW'(lo_ff[k]);
   end

   assign sum_in = SW'(term[0]) + SW'(term[1]) + SW'(term[2]);

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      sum_ff <= sum_in;
   end

   assign result = sum_ff;

endmodule
